>>> hdl/dscv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decaying sine click voice package
// Shared types, constants, the semitone ratio table and the sine table builder.
// ----------------------------------------------------------------------------
package dscv_pkg;

    // Field widths
    localparam int unsigned NOTE_W    = 7;
    localparam int unsigned VEL_W     = 16;
    localparam int unsigned OCT_W     = 4;
    localparam int unsigned SEMI_W    = 4;
    localparam int unsigned RATIO_W   = 21;
    localparam int unsigned SHIFT_W   = 5;
    localparam int unsigned PHASE_W   = 32;
    localparam int unsigned AMP_W     = 16;
    localparam int unsigned ENV_W     = 24;
    localparam int unsigned OUT_W     = 16;
    localparam int unsigned CFG_W     = 32;

    // Shared multiplier
    localparam int unsigned MUL_A_W   = 32;
    localparam int unsigned MUL_B_W   = 24;
    localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned STEP_PROD_W = PHASE_W + RATIO_W;

    // Low slice of |sine|*amplitude, multiplied by the envelope on its own
    localparam int unsigned MAG_LO_W  = 20;

    // note / 12 as (note * 171) >> 11, exact for 7-bit notes
    localparam logic [7:0]         OCT_RECIP       = 8'd171;
    localparam int unsigned        OCT_RECIP_SHIFT = 11;
    localparam logic [NOTE_W-1:0]  SEMIS_PER_OCT   = 7'd12;
    // step = (a4 * ratio) >> (25 - octave), ratio in Q1.20, octave 5 unshifted
    localparam logic [SHIFT_W-1:0] STEP_BASE_SHIFT = 5'd25;

    localparam logic [MUL_B_W-1:0] AMP_SCALE = 24'd9830;   // 0.15 in Q0.16
    localparam logic [31:0]        AMP_ROUND = 32'd32768;
    localparam logic [ENV_W-1:0]   ENV_FULL  = 24'hFF_FFFF;

    // Configuration registers
    localparam int unsigned        APB_ADDR_W = 4;
    localparam logic [1:0]         REG_PHASE_STEP_A4 = 2'd0;
    localparam logic [1:0]         REG_DECAY_FACTOR  = 2'd1;
    localparam logic [1:0]         REG_STOP_THRESH   = 2'd2;
    localparam logic [31:0]        RST_PHASE_STEP_A4 = 32'd39370534;
    localparam logic [ENV_W-1:0]   RST_DECAY_FACTOR  = 24'd16760439;
    localparam logic [ENV_W-1:0]   RST_STOP_THRESH   = 24'd83886;

    // Command queue
    localparam int unsigned CMD_QUEUE_DEPTH = 2;
    localparam int unsigned CMD_QUEUE_PTR_W = $clog2(CMD_QUEUE_DEPTH);

    // Sine table build
    localparam int unsigned     ROM_ENTRY_W = 23;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic                start;
        logic [RATIO_W-1:0]  ratio;
        logic [SHIFT_W-1:0]  shift;
        logic [VEL_W-1:0]    velocity;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic sounding;
        logic silent_pop;
    } t_back_status;

    // 2^((s-9)/12) in Q1.20
    function automatic logic [RATIO_W-1:0] f_semitone_ratio(input logic [SEMI_W-1:0] semi);
        logic [RATIO_W-1:0] r;
        unique case (semi)
            4'd0:    r = 21'd623487;
            4'd1:    r = 21'd660561;
            4'd2:    r = 21'd699841;
            4'd3:    r = 21'd741455;
            4'd4:    r = 21'd785544;
            4'd5:    r = 21'd832255;
            4'd6:    r = 21'd881744;
            4'd7:    r = 21'd934175;
            4'd8:    r = 21'd989724;
            4'd9:    r = 21'd1048576;
            4'd10:   r = 21'd1110928;
            4'd11:   r = 21'd1176987;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Quarter-wave entry idx, sampled at bin centers; Q2.30 Horner series to x^11.
    // Evaluated at elaboration only.
    function automatic logic [ROM_ENTRY_W-1:0] f_sine_entry(input int unsigned idx,
                                                            input int unsigned stb,
                                                            input int unsigned sb);
        longint unsigned full;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        full = (64'd1 << (sb - 1)) - 64'd1;
        x    = ((64'd2 * longint'(idx) + 64'd1) * HALF_PI_Q30) >> (stb - 1);
        x2   = (x * x) >> 30;
        t    = ONE_Q30 - x2 / 110;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s    = (x * t) >> 30;
        v    = (s * full + (64'd1 << 29)) >> 30;
        if (v > full) begin
            v = full;
        end
        return ROM_ENTRY_W'(v);
    endfunction

endpackage

>>> hdl/dscv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Click voice channels
// Valid/ready channels for input items and output samples.
// ----------------------------------------------------------------------------
interface dscv_in_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [dscv_pkg::NOTE_W-1:0] note;
    logic [dscv_pkg::VEL_W-1:0]  velocity;

    modport source (output valid, output op, output note, output velocity, input ready);
    modport sink   (input valid, input op, input note, input velocity, output ready);
endinterface

interface dscv_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [dscv_pkg::OUT_W-1:0] sample;
    logic                             voice_active;

    modport source (output valid, output sample, output voice_active, input ready);
    modport sink   (input valid, input sample, input voice_active, output ready);
endinterface

>>> hdl/decaying_sine_click_voice_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decaying sine click voice
// One metronome click voice: DDS sine, velocity amplitude, exponential decay.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one beat per item: op 0 is a sample tick, op 1 starts a note
//   (note, velocity). A start returns nothing; every tick returns one beat on
//   o_out with a Q1.15 sample and voice_active (still sounding after it).
//   psel/penable/pwrite/paddr/pwdata program phase_step_a4 (0x0),
//   decay_factor (0x4) and stop_threshold (0x8); reads return the values.
//   Change them only while the voice is idle.
// Sequencing:
//   The front decodes beats into a two-deep queue; the back pops one command
//   at a time. A tick on a sounding voice runs IDLE, T_QA, T_HI, T_LO and
//   T_EMIT, driving four products through the one shared 32x24 multiplier
//   (envelope*decay, sine*amplitude, and two halves of that times the
//   envelope). A silent tick is loaded into the output register from idle;
//   a start runs S_AMP and S_DONE.
// Reset (i_rst_n low, synchronous): registers take their defaults, the queue
//   empties and the voice is silent. No clearing pass.
// Stall: results sit in the output register until o_out.ready; meanwhile the
//   queue keeps taking beats until it is full, then i_in.ready drops.
// ----------------------------------------------------------------------------
module decaying_sine_click_voice_unit #(
    parameter int unsigned SINE_TABLE_BITS = 10,
    parameter int unsigned SAMPLE_BITS     = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dscv_in_if.sink                           i_in,
    dscv_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dscv_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dscv_pkg::CFG_W-1:0]        pwdata,
    output logic [dscv_pkg::CFG_W-1:0]        prdata,
    output logic                              pready
);

    // configuration registers
    logic [dscv_pkg::PHASE_W-1:0]  r_phase_step_a4;
    logic [dscv_pkg::ENV_W-1:0]    r_decay_factor;
    logic [dscv_pkg::ENV_W-1:0]    r_stop_threshold;
    logic                          w_cfg_wr;
    logic [1:0]                    w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step_a4  <= dscv_pkg::RST_PHASE_STEP_A4;
            r_decay_factor   <= dscv_pkg::RST_DECAY_FACTOR;
            r_stop_threshold <= dscv_pkg::RST_STOP_THRESH;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                dscv_pkg::REG_PHASE_STEP_A4: r_phase_step_a4  <= pwdata;
                dscv_pkg::REG_DECAY_FACTOR:  r_decay_factor   <= pwdata[dscv_pkg::ENV_W-1:0];
                dscv_pkg::REG_STOP_THRESH:   r_stop_threshold <= pwdata[dscv_pkg::ENV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            dscv_pkg::REG_PHASE_STEP_A4: prdata = r_phase_step_a4;
            dscv_pkg::REG_DECAY_FACTOR:  prdata = dscv_pkg::CFG_W'(r_decay_factor);
            dscv_pkg::REG_STOP_THRESH:   prdata = dscv_pkg::CFG_W'(r_stop_threshold);
            default:                     prdata = '0;
        endcase
    end

    // front -> queue -> back
    logic                      w_cmd_valid;
    dscv_pkg::t_cmd            w_cmd;
    logic                      w_cmd_ready;
    logic                      w_head_valid;
    dscv_pkg::t_cmd            w_head;
    logic                      w_pop;
    dscv_pkg::t_q_status       w_q_status;
    dscv_pkg::t_back_status    w_back_status;

    dscv_front u_front (
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    dscv_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_cmd_valid),
        .i_push_cmd   (w_cmd),
        .o_push_ready (w_cmd_ready),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop),
        .o_status     (w_q_status)
    );

    dscv_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (w_head_valid),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .i_phase_step_a4  (r_phase_step_a4),
        .i_decay_factor   (r_decay_factor),
        .i_stop_threshold (r_stop_threshold),
        .o_status         (w_back_status),
        .o_out            (o_out)
    );

    // a pop never reaches an empty queue
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty command queue");

    // a tick on a silent voice gives a zero, inactive sample next cycle
    a_silent_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_status.silent_pop |=>
            (o_out.valid && (o_out.sample == '0) && !o_out.voice_active))
        else $error("silent tick result wrong");

    // a pending active result implies the voice is still sounding
    a_active_sounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.voice_active) |-> w_back_status.sounding)
        else $error("active result while voice silent");

endmodule

>>> hdl/dscv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Click voice front end
// Takes input beats and decodes them into commands: op, ratio, octave shift.
// ----------------------------------------------------------------------------
module dscv_front (
    dscv_in_if.sink              i_in,
    output logic                 o_cmd_valid,
    output dscv_pkg::t_cmd       o_cmd,
    input  logic                 i_cmd_ready
);

    logic [14:0]                     w_oct_prod;
    logic [dscv_pkg::OCT_W-1:0]      w_oct;
    logic [dscv_pkg::NOTE_W-1:0]     w_semi_full;

    assign w_oct_prod  = 15'(i_in.note) * 15'(dscv_pkg::OCT_RECIP);
    assign w_oct       = w_oct_prod[14:dscv_pkg::OCT_RECIP_SHIFT];
    assign w_semi_full = i_in.note - dscv_pkg::NOTE_W'(w_oct) * dscv_pkg::SEMIS_PER_OCT;

    assign o_cmd_valid    = i_in.valid;
    assign i_in.ready     = i_cmd_ready;
    assign o_cmd.start    = i_in.op;
    assign o_cmd.ratio    = dscv_pkg::f_semitone_ratio(w_semi_full[dscv_pkg::SEMI_W-1:0]);
    assign o_cmd.shift    = dscv_pkg::STEP_BASE_SHIFT - dscv_pkg::SHIFT_W'(w_oct);
    assign o_cmd.velocity = i_in.velocity;

endmodule

>>> hdl/dscv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Click voice command queue
// Short FIFO between front and back end.
// ----------------------------------------------------------------------------
module dscv_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push_valid,
    input  dscv_pkg::t_cmd        i_push_cmd,
    output logic                  o_push_ready,
    output logic                  o_head_valid,
    output dscv_pkg::t_cmd        o_head,
    input  logic                  i_pop,
    output dscv_pkg::t_q_status   o_status
);

    localparam int unsigned PW = dscv_pkg::CMD_QUEUE_PTR_W;

    dscv_pkg::t_cmd  r_mem [dscv_pkg::CMD_QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;
    logic            w_push;
    logic            w_pop;

    assign o_status.full  = (r_count == (PW+1)'(dscv_pkg::CMD_QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_push_ready   = !o_status.full;
    assign o_head_valid   = !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];
    assign w_push         = i_push_valid && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

endmodule

>>> hdl/dscv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Click voice back end
// Voice state, sine table and a shared 32x24 multiplier sequenced per command.
// ----------------------------------------------------------------------------
module dscv_back #(
    parameter int unsigned SINE_TABLE_BITS = 10,
    parameter int unsigned SAMPLE_BITS     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  dscv_pkg::t_cmd                i_head,
    output logic                          o_pop,
    input  logic [dscv_pkg::PHASE_W-1:0]  i_phase_step_a4,
    input  logic [dscv_pkg::ENV_W-1:0]    i_decay_factor,
    input  logic [dscv_pkg::ENV_W-1:0]    i_stop_threshold,
    output dscv_pkg::t_back_status        o_status,
    dscv_out_if.source                    o_out
);

    localparam int unsigned QLEN  = 1 << (SINE_TABLE_BITS - 2);
    localparam int unsigned KW    = SINE_TABLE_BITS - 2;
    localparam int unsigned QW    = SAMPLE_BITS - 1;
    localparam int unsigned MW    = QW + dscv_pkg::AMP_W;
    localparam int unsigned LOW   = dscv_pkg::MAG_LO_W;
    localparam int unsigned HW    = MW - LOW;
    localparam int unsigned EW    = dscv_pkg::ENV_W;
    localparam int unsigned ACC_W = HW + EW;
    localparam int unsigned SUM_W = MW + EW + 1;
    localparam int unsigned OW    = dscv_pkg::OUT_W;
    localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (SAMPLE_BITS + 23);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_S_AMP  = 7'b0000010,
        ST_S_DONE = 7'b0000100,
        ST_T_QA   = 7'b0001000,
        ST_T_HI   = 7'b0010000,
        ST_T_LO   = 7'b0100000,
        ST_T_EMIT = 7'b1000000
    } t_state;

    // quarter-wave sine table
    logic [QW-1:0] w_rom [QLEN];
    for (genvar g = 0; g < QLEN; g++) begin : g_rom
        localparam logic [dscv_pkg::ROM_ENTRY_W-1:0] ENTRY =
            dscv_pkg::f_sine_entry(g, SINE_TABLE_BITS, SAMPLE_BITS);
        assign w_rom[g] = ENTRY[QW-1:0];
    end

    t_state                            r_state;
    t_state                            n_state;
    logic                              r_sounding;
    logic [dscv_pkg::PHASE_W-1:0]      r_phase;
    logic [dscv_pkg::PHASE_W-1:0]      r_step;
    logic [dscv_pkg::AMP_W-1:0]        r_amp;
    logic [EW-1:0]                     r_env;
    logic [EW-1:0]                     r_env_next;
    logic [dscv_pkg::SHIFT_W-1:0]      r_shift;
    logic [dscv_pkg::VEL_W-1:0]        r_vel;
    logic [QW-1:0]                     r_q;
    logic                              r_neg;
    logic [LOW-1:0]                    r_lo;
    logic [ACC_W-1:0]                  r_acc;
    logic [dscv_pkg::MUL_P_W-1:0]      r_prod;
    logic                              r_out_valid;
    logic signed [OW-1:0]              r_sample;
    logic                              r_active;

    logic [dscv_pkg::MUL_A_W-1:0]      w_mul_a;
    logic [dscv_pkg::MUL_B_W-1:0]      w_mul_b;
    logic [dscv_pkg::MUL_P_W-1:0]      w_prod;
    logic                              w_mul_en;
    logic                              w_out_free;
    logic                              w_out_load;
    logic signed [OW-1:0]              w_out_sample;
    logic                              w_out_active;
    logic                              w_silent_pop;
    logic [KW-1:0]                     w_k;
    logic [dscv_pkg::STEP_PROD_W-1:0]  w_step_full;
    logic [31:0]                       w_amp_sum;
    logic [SUM_W-1:0]                  w_sum;
    logic [OW-1:0]                     w_mag;
    logic [OW-2:0]                     w_mag_sat;
    logic signed [OW-1:0]              w_sample;
    logic                              w_env_live;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_k = r_phase[30] ? ~r_phase[29 -: KW] : r_phase[29 -: KW];
    assign w_prod = w_mul_a * w_mul_b;
    assign w_step_full = r_prod[dscv_pkg::STEP_PROD_W-1:0] >> r_shift;
    assign w_amp_sum = r_prod[31:0] + dscv_pkg::AMP_ROUND;

    // |sine|*amp*env = (hi*env << LOW) + lo*env, rounded to Q1.15
    assign w_sum = SUM_W'({r_acc, {LOW{1'b0}}}) + SUM_W'(r_prod[LOW+EW-1:0]) + RND;
    assign w_mag = w_sum[SUM_W-1:SAMPLE_BITS+24];
    assign w_mag_sat = w_mag[OW-1] ? {(OW-1){1'b1}} : w_mag[OW-2:0];
    assign w_sample = r_neg ? OW'(0) - {1'b0, w_mag_sat} : {1'b0, w_mag_sat};
    assign w_env_live = (r_env_next > i_stop_threshold);

    always_comb begin
        n_state      = r_state;
        o_pop        = 1'b0;
        w_mul_en     = 1'b0;
        w_mul_a      = '0;
        w_mul_b      = '0;
        w_out_load   = 1'b0;
        w_out_sample = '0;
        w_out_active = 1'b0;
        w_silent_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    priority if (i_head.start) begin
                        o_pop    = 1'b1;
                        w_mul_en = 1'b1;
                        w_mul_a  = i_phase_step_a4;
                        w_mul_b  = dscv_pkg::MUL_B_W'(i_head.ratio);
                        n_state  = ST_S_AMP;
                    end else if (r_sounding) begin
                        o_pop    = 1'b1;
                        w_mul_en = 1'b1;
                        w_mul_a  = dscv_pkg::MUL_A_W'(r_env);
                        w_mul_b  = i_decay_factor;
                        n_state  = ST_T_QA;
                    end else if (w_out_free) begin
                        o_pop        = 1'b1;
                        w_out_load   = 1'b1;
                        w_silent_pop = 1'b1;
                    end else begin
                        // silent tick waits for the output register
                        o_pop = 1'b0;
                    end
                end
            end
            ST_S_AMP: begin
                w_mul_en = 1'b1;
                w_mul_a  = dscv_pkg::MUL_A_W'(r_vel);
                w_mul_b  = dscv_pkg::AMP_SCALE;
                n_state  = ST_S_DONE;
            end
            ST_S_DONE: begin
                n_state = ST_IDLE;
            end
            ST_T_QA: begin
                w_mul_en = 1'b1;
                w_mul_a  = dscv_pkg::MUL_A_W'(r_q);
                w_mul_b  = dscv_pkg::MUL_B_W'(r_amp);
                n_state  = ST_T_HI;
            end
            ST_T_HI: begin
                w_mul_en = 1'b1;
                w_mul_a  = dscv_pkg::MUL_A_W'(r_prod[MW-1:LOW]);
                w_mul_b  = r_env;
                n_state  = ST_T_LO;
            end
            ST_T_LO: begin
                w_mul_en = 1'b1;
                w_mul_a  = dscv_pkg::MUL_A_W'(r_lo);
                w_mul_b  = r_env;
                n_state  = ST_T_EMIT;
            end
            ST_T_EMIT: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    w_out_sample = w_sample;
                    w_out_active = w_env_live;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sounding  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_S_DONE) begin
                r_sounding <= 1'b1;
            end else if (r_state == ST_T_EMIT && w_out_free) begin
                r_sounding <= w_env_live;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        if (w_out_load) begin
            r_sample <= w_out_sample;
            r_active <= w_out_active;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop && i_head.start) begin
                    r_shift <= i_head.shift;
                    r_vel   <= i_head.velocity;
                end
                r_q   <= w_rom[w_k];
                r_neg <= r_phase[31];
            end
            ST_S_AMP: begin
                r_step <= w_step_full[dscv_pkg::PHASE_W-1:0];
            end
            ST_S_DONE: begin
                r_amp   <= w_amp_sum[31:16];
                r_env   <= dscv_pkg::ENV_FULL;
                r_phase <= '0;
            end
            ST_T_QA: begin
                r_env_next <= r_prod[2*EW-1:EW];
            end
            ST_T_HI: begin
                r_lo <= r_prod[LOW-1:0];
            end
            ST_T_LO: begin
                r_acc <= r_prod[ACC_W-1:0];
            end
            ST_T_EMIT: begin
                if (w_out_free) begin
                    r_phase <= r_phase + r_step;
                    r_env   <= r_env_next;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sample       = r_sample;
    assign o_out.voice_active = r_active;

    assign o_status.sounding   = r_sounding;
    assign o_status.silent_pop = w_silent_pop;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Click voice testbench
// Drives start and tick beats into the decaying sine click voice and programs
// its registers over APB. A scoreboard class predicts every tick's sample and
// voice_active and compares them with the output beats in order.
// ----------------------------------------------------------------------------
module testbench;

    // Block parameters mirrored by the predictor
    localparam int unsigned SINE_BITS = 10;
    localparam int unsigned SMP_BITS  = 16;
    localparam int unsigned QTR_LEN   = 1 << (SINE_BITS - 2);

    // Beat opcodes and the one register index outside the map
    localparam logic       OP_TICK    = 1'b0;
    localparam logic       OP_START   = 1'b1;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Pacing
    localparam int unsigned LIGHT_IDLE_PCT = 19;
    localparam int unsigned HEAVY_IDLE_PCT = 77;
    localparam int unsigned START_PCT      = 8;
    localparam int unsigned N_SEGS         = 9;
    localparam int unsigned SEG_ITEMS      = 110;
    localparam int unsigned PAUSE_SEG      = 7;
    localparam int unsigned HOLD_AT        = 700;   // sample beats before the long hold-off
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned SETTLE_CYCLES  = 20;    // room for two queued starts to finish, plus slack
    localparam int unsigned LIMIT_CYCLES   = 400_000;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef enum int {SLOW_SINK, SLOW_SOURCE, NO_GAPS} t_pacing;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the voice and the registers, turns
    // each accepted tick into the expected sample beat, and checks the output.
    // ------------------------------------------------------------------------
    class t_click_scoreboard;
        // Registers
        logic [31:0] a4_step;
        logic [23:0] decay;
        logic [23:0] thresh;
        // Voice
        logic [31:0] phase;
        logic [31:0] step;
        logic [15:0] amp;
        logic [23:0] env;
        logic        sounding;

        int unsigned sine_q[QTR_LEN];
        int unsigned ratio_q20[12] = '{623487, 660561, 699841, 741455, 785544, 832255,
                                       881744, 934175, 989724, 1048576, 1110928, 1176987};

        logic signed [15:0] want_sample_q[$];
        logic               want_active_q[$];

        int n_starts;
        int n_ticks;
        int n_checked;
        int errors;

        function new();
            for (int i = 0; i < QTR_LEN; i++) sine_q[i] = quarter_sine(i);
            a4_step   = 32'd39370534;
            decay     = 24'd16760439;
            thresh    = 24'd83886;
            phase     = '0;
            step      = '0;
            amp       = '0;
            env       = '0;
            sounding  = 1'b0;
            n_starts  = 0;
            n_ticks   = 0;
            n_checked = 0;
            errors    = 0;
        endfunction

        // Bin-centered quarter-wave entry; truncating Q2.30 Horner series to x^11
        function int unsigned quarter_sine(int unsigned i);
            longint unsigned one_q30;
            longint unsigned full;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned t;
            longint unsigned v;
            one_q30 = 64'd1 << 30;
            full    = (64'd1 << (SMP_BITS - 1)) - 64'd1;
            x  = ((64'd2 * i + 64'd1) * 64'd1686629713) / (64'd2 * QTR_LEN);
            x2 = (x * x) >> 30;
            t  = one_q30 - x2 / 64'd110;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd72;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd42;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd20;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd6;
            v  = (((x * t) >> 30) * full + (64'd1 << 29)) >> 30;
            if (v > full) v = full;
            return int'(v);
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                dscv_pkg::REG_PHASE_STEP_A4: a4_step = val;
                dscv_pkg::REG_DECAY_FACTOR:  decay   = val[23:0];
                dscv_pkg::REG_STOP_THRESH:   thresh  = val[23:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic op, logic [6:0] note, logic [15:0] vel);
            int unsigned     oct;
            int unsigned     semi;
            int unsigned     idx;
            int unsigned     quad;
            int unsigned     k;
            longint unsigned prod;
            longint unsigned mag;
            logic [15:0]     s;
            if (op == OP_START) begin
                n_starts++;
                oct  = note / 12;
                semi = note % 12;
                prod = 64'(a4_step) * 64'(ratio_q20[semi]);
                if (oct >= 5) prod = (prod << (oct - 5)) >> 20;
                else          prod = prod >> (25 - oct);
                step     = 32'(prod);
                phase    = '0;
                amp      = 16'((64'(vel) * 64'd9830 + 64'd32768) >> 16);
                env      = 24'hFF_FFFF;
                sounding = 1'b1;
                return;
            end
            n_ticks++;
            if (!sounding) begin
                want_sample_q.push_back('0);
                want_active_q.push_back(1'b0);
                return;
            end
            idx  = phase >> (32 - SINE_BITS);
            quad = idx >> (SINE_BITS - 2);
            k    = idx & (QTR_LEN - 1);
            if (quad & 1) k = QTR_LEN - 1 - k;
            mag = 64'(sine_q[k]) * 64'(amp);
            mag = (mag * 64'(env) + (64'd1 << (SMP_BITS + 23))) >> (SMP_BITS + 24);
            if (mag > 64'd32767) mag = 64'd32767;
            s = 16'(mag);
            if (quad & 2) s = -s;
            phase = phase + step;
            env   = 24'((64'(env) * 64'(decay)) >> 24);
            if (env <= thresh) sounding = 1'b0;
            want_sample_q.push_back(s);
            want_active_q.push_back(sounding);
        endfunction

        function void check_sample(logic signed [15:0] got_smp, logic got_act);
            logic signed [15:0] want_smp;
            logic               want_act;
            if (want_sample_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("MISCOMPARE: unexpected sample beat, sample %0d active %0b",
                             got_smp, got_act);
                return;
            end
            want_smp = want_sample_q.pop_front();
            want_act = want_active_q.pop_front();
            n_checked++;
            if (got_smp !== want_smp || got_act !== want_act) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("MISCOMPARE: sample beat %0d expected %0d/%0b, got %0d/%0b",
                             n_checked, want_smp, want_act, got_smp, got_act);
            end
        endfunction

        function int pending();
            return want_sample_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and channels
    // ------------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [dscv_pkg::APB_ADDR_W-1:0] paddr;
    logic [dscv_pkg::CFG_W-1:0]      pwdata;
    logic [dscv_pkg::CFG_W-1:0]      prdata;
    logic                            pready;

    dscv_in_if  in_if ();
    dscv_out_if out_if ();

    decaying_sine_click_voice_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_click_scoreboard      sb;
    t_pacing                pacing;        // written by the stimulus process only
    int                     beats_seen;    // written by the sink process only
    int                     n_settings;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Idle decisions per phase: the sender and sink swap the light and heavy
    // rates, then both run flat out.
    function automatic bit tx_gap();
        case (pacing)
            SLOW_SINK:   return $urandom_range(0, 99) < LIGHT_IDLE_PCT;
            SLOW_SOURCE: return $urandom_range(0, 99) < HEAVY_IDLE_PCT;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit rx_gap();
        case (pacing)
            SLOW_SINK:   return $urandom_range(0, 99) < HEAVY_IDLE_PCT;
            SLOW_SOURCE: return $urandom_range(0, 99) < LIGHT_IDLE_PCT;
            default:     return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side. valid stays high from one beat to the next unless a gap is
    // rolled, so it is never dropped and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [6:0] note, input logic [15:0] vel);
        if (tx_gap()) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while (tx_gap());
        end
        in_if.valid    <= 1'b1;
        in_if.op       <= op;
        in_if.note     <= note;
        in_if.velocity <= vel;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(op, note, vel);
    endtask

    // Ticks carry random note/velocity; the block must ignore them
    task automatic send_tick();
        send_item(OP_TICK, 7'($urandom_range(0, 127)), 16'($urandom));
    endtask

    // Stop offering beats and wait until every sample beat is back. Starts
    // give no beat, so a queued start may still be in flight: settle after.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup, then access; the register takes the value at the edge
    // where psel, penable, pwrite and pready are all high.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reprogram(input logic [31:0] a4, input logic [23:0] dec,
                             input logic [23:0] thr);
        drain();
        apb_write(dscv_pkg::REG_PHASE_STEP_A4, a4);
        apb_write(dscv_pkg::REG_DECAY_FACTOR, {8'd0, dec});
        apb_write(dscv_pkg::REG_STOP_THRESH, {8'd0, thr});
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: checks every accepted sample beat and paces ready. Once,
    // after HOLD_AT beats, it holds ready low for a long stretch so the queue
    // fills and the input stalls.
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        beats_seen   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                sb.check_sample(out_if.sample, out_if.voice_active);
                beats_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (!hold_done && beats_seen >= HOLD_AT) begin
                hold_done     = 1'b1;
                hold_left     = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !rx_gap();
            end
        end
    end

    // Watchdog
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("decaying_sine_click_voice_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] a4_val;
        logic [23:0] dec_val;
        logic [23:0] thr_val;
        sb             = new();
        pacing         = SLOW_SINK;
        n_settings     = 0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.op       = OP_TICK;
        in_if.note     = '0;
        in_if.velocity = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset register values first.
        send_tick();                              // silent after reset: 0 / inactive
        send_item(OP_START, 7'd69, 16'hFFFF);     // A4, full velocity
        repeat (3) send_tick();
        send_item(OP_START, 7'd0, 16'h0000);      // retrigger while sounding, zero velocity
        repeat (2) send_tick();
        send_item(OP_START, 7'd127, 16'h8000);    // top note, octave shift left
        repeat (3) send_tick();
        send_item(OP_START, 7'd59, 16'h0001);     // last note below the unshifted octave
        send_tick();

        // Threshold at full scale: one sounding tick, then silence
        reprogram(32'd39370534, 24'd16760439, 24'hFF_FFFF);
        send_item(OP_START, 7'd60, 16'hFFFF);
        repeat (2) send_tick();

        // Zero decay factor, largest step: product wraps, voice stops after one tick
        reprogram(32'hFFFF_FFFF, 24'd0, 24'd0);
        send_item(OP_START, 7'd127, 16'hFFFF);
        send_tick();

        // Zero step holds the phase; slowest possible decay
        reprogram(32'd0, 24'hFF_FFFF, 24'd0);
        send_item(OP_START, 7'd69, 16'hFFFF);
        repeat (2) send_tick();

        // A write past the register map must change nothing
        reprogram(32'hFFFF_FFFF, 24'hFF_FFFF, 24'd0);
        apb_write(REG_UNUSED, $urandom);
        send_item(OP_START, 7'd127, 16'hFFFF);
        repeat (2) send_tick();

        // Random part: each segment reprograms, opens with a start, then runs
        // mostly ticks with the odd retrigger.
        for (int seg = 0; seg < N_SEGS; seg++) begin
            pacing = (seg < 3) ? SLOW_SINK : (seg < 6) ? SLOW_SOURCE : NO_GAPS;
            case ($urandom_range(0, 5))
                0:       a4_val = 32'd0;
                1:       a4_val = 32'hFFFF_FFFF;
                default: a4_val = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       dec_val = 24'd0;
                1:       dec_val = 24'hFF_FFFF;
                2:       dec_val = 24'($urandom);
                default: dec_val = 24'($urandom_range(24'hFF_FFFF, 24'hF8_0000));
            endcase
            case ($urandom_range(0, 7))
                0:       thr_val = 24'd0;
                1:       thr_val = 24'hFF_FFFF;
                2:       thr_val = 24'($urandom);
                default: thr_val = 24'($urandom_range(0, 24'h08_0000));
            endcase
            reprogram(a4_val, dec_val, thr_val);
            send_item(OP_START, 7'($urandom_range(0, 127)), 16'($urandom));
            for (int n = 1; n < SEG_ITEMS; n++) begin
                // Sender pause: let everything outstanding come back first
                if (seg == PAUSE_SEG && n == SEG_ITEMS / 2) drain();
                if ($urandom_range(0, 99) < START_PCT)
                    send_item(OP_START, 7'($urandom_range(0, 127)), 16'($urandom));
                else
                    send_tick();
            end
        end

        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d starts and %0d ticks over %0d register settings; %0d beats compared.",
                 sb.n_starts, sb.n_ticks, n_settings, sb.n_checked);
        $display("Pacing: slow sink, slow source, no gaps, a long sink hold-off, a drain pause.");
        if (sb.errors == 0) begin
            $display("decaying_sine_click_voice_unit: match");
        end else begin
            $display("decaying_sine_click_voice_unit: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/dscv_pkg.sv
hdl/dscv_if.sv
hdl/dscv_front.sv
hdl/dscv_queue.sv
hdl/dscv_back.sv
hdl/decaying_sine_click_voice_unit.sv
bench/testbench.sv
